// ===== hw/rtl/lrt_pkg.sv =====
`default_nettype none
package lrt_pkg;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOROUTE  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_HOPFULL  = 3'd3;
  localparam logic [2:0] ST_TABFULL  = 3'd4;

  localparam logic [5:0] MAX_LEN = 6'd32;

  // Network mask for a prefix length of 0..32.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - len);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lrt_ram.sv =====
`default_nettype none
module lrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(Depth)-1:0]  waddr_i,
  input  wire  [Width-1:0]          wdata_i,
  input  wire  [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lpm_route_table_ecmp.sv =====
`default_nettype none
// IPv4 longest-prefix-match route table with round-robin ECMP next hops.
// One request (lookup, add, delete, clear non-direct) gives one result.
// Every request scans all ROUTE_ENTRIES entries of the route memory, one
// entry per cycle. The result then passes S_DECIDE and S_DONE to the output
// register, and the next request can be taken as the result becomes valid.
// A lookup hit adds S_RECV for the entry read, plus S_LKHOP for the
// next-hop read and round-robin write-back when the route has next hops.
// An add of a next hop to an existing route adds S_RECV for the entry
// read, S_HRD and S_HCMP per stored next hop for the duplicate check, and
// S_APPEND for the append.
// The next request is taken while a finished result waits on the output.
module lpm_route_table_ecmp #(
  parameter int ROUTE_ENTRIES = 64,
  parameter int NEXTHOPS      = 4,
  parameter int INTERFACES    = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  kind_i,
  input  wire  [31:0] dest_ip_i,
  input  wire  [5:0]  prefix_len_i,
  input  wire         has_nexthop_i,
  input  wire  [31:0] gateway_ip_i,
  input  wire  [3:0]  out_intf_i,
  input  wire  [31:0] metric_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  status_o,
  output logic        route_direct_o,
  output logic [31:0] nexthop_ip_o,
  output logic [3:0]  nexthop_intf_o,
  output logic [31:0] route_metric_o,
  output logic [5:0]  matched_prefix_len_o
);
  import lrt_pkg::*;

  localparam int IdxW = $clog2(ROUTE_ENTRIES);
  localparam int CntW = $clog2(NEXTHOPS + 1);
  localparam int HkW  = (NEXTHOPS > 1) ? $clog2(NEXTHOPS) : 1;
  localparam int HopD = ROUTE_ENTRIES * NEXTHOPS;
  localparam int HaW  = $clog2(HopD);
  localparam logic [CntW-1:0] NhCnt = CntW'(NEXTHOPS);

  typedef struct packed {
    logic [31:0]     prefix;
    logic [5:0]      len;
    logic [31:0]     metric;
    logic [CntW-1:0] cnt;
    logic [HkW-1:0]  rr;
  } ent_t;

  typedef struct packed {
    logic [31:0] gw;
    logic [3:0]  intf;
  } hop_t;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_RECV   = 4'd3;
  localparam logic [3:0] S_HRD    = 4'd4;
  localparam logic [3:0] S_HCMP   = 4'd5;
  localparam logic [3:0] S_LKHOP  = 4'd6;
  localparam logic [3:0] S_APPEND = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_q, state_d;

  // request
  logic [1:0]  kind_q;
  logic [31:0] dest_q, prefix_q, gw_q, metric_q;
  logic [5:0]  len_q;
  logic        has_q;
  logic [3:0]  intf_q;

  logic [ROUTE_ENTRIES-1:0] vld_q, vld_d;
  logic [IdxW:0]   rd_cnt_q, rd_cnt_d;
  logic            pvld_q, pvld_d;
  logic [IdxW-1:0] pidx_q, pidx_d;

  logic            best_f_q, best_f_d, dflt_f_q, dflt_f_d;
  logic            match_f_q, match_f_d, free_f_q, free_f_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d, dflt_idx_q, dflt_idx_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic [IdxW-1:0] tgt_q, tgt_d;
  logic [5:0]      best_len_q, best_len_d;

  ent_t            cur_q, cur_d;
  logic [HkW-1:0]  k_q, k_d, rr_nxt_q, rr_nxt_d;

  logic [2:0]  r_status_q, r_status_d;
  logic        r_direct_q, r_direct_d;
  logic [31:0] r_ip_q, r_ip_d, r_metric_q, r_metric_d;
  logic [3:0]  r_intf_q, r_intf_d;
  logic [5:0]  r_len_q, r_len_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  o_status_q;
  logic        o_direct_q;
  logic [31:0] o_ip_q, o_metric_q;
  logic [3:0]  o_intf_q;
  logic [5:0]  o_len_q;

  logic            ent_we, hop_we;
  logic [IdxW-1:0] ent_wa, ent_ra;
  ent_t            ent_wd, ent_rd;
  logic [HaW-1:0]  hop_wa, hop_ra;
  hop_t            hop_wd, hop_rd;

  logic in_acc, out_load;
  logic [5:0]  sat_len;
  logic [31:0] in_prefix;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign sat_len    = (prefix_len_i > MAX_LEN) ? MAX_LEN : prefix_len_i;
  assign in_prefix  = dest_ip_i & len_mask(sat_len);

  function automatic logic [HaW-1:0] hop_addr(input logic [IdxW-1:0] e,
                                              input logic [HkW-1:0] k);
    return HaW'(HaW'(e) * HaW'(NEXTHOPS)) + HaW'(k);
  endfunction

  lrt_ram #(.Width($bits(ent_t)), .Depth(ROUTE_ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_wa),
    .wdata_i (ent_wd),
    .raddr_i (ent_ra),
    .rdata_o (ent_rd)
  );

  lrt_ram #(.Width($bits(hop_t)), .Depth(HopD)) u_hop_ram (
    .clk_i   (clk_i),
    .we_i    (hop_we),
    .waddr_i (hop_wa),
    .wdata_i (hop_wd),
    .raddr_i (hop_ra),
    .rdata_o (hop_rd)
  );

  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    rd_cnt_d    = rd_cnt_q;
    pvld_d      = 1'b0;
    pidx_d      = pidx_q;
    best_f_d    = best_f_q;
    dflt_f_d    = dflt_f_q;
    match_f_d   = match_f_q;
    free_f_d    = free_f_q;
    best_idx_d  = best_idx_q;
    dflt_idx_d  = dflt_idx_q;
    match_idx_d = match_idx_q;
    free_idx_d  = free_idx_q;
    best_len_d  = best_len_q;
    tgt_d       = tgt_q;
    cur_d       = cur_q;
    k_d         = k_q;
    rr_nxt_d    = rr_nxt_q;
    r_status_d  = r_status_q;
    r_direct_d  = r_direct_q;
    r_ip_d      = r_ip_q;
    r_intf_d    = r_intf_q;
    r_metric_d  = r_metric_q;
    r_len_d     = r_len_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    ent_we      = 1'b0;
    ent_wa      = tgt_q;
    ent_wd      = cur_q;
    ent_ra      = rd_cnt_q[IdxW-1:0];
    hop_we      = 1'b0;
    hop_wa      = hop_addr(tgt_q, k_q);
    hop_wd      = '{gw: gw_q, intf: intf_q};
    hop_ra      = hop_addr(tgt_q, k_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rd_cnt_d   = '0;
          best_f_d   = 1'b0;
          dflt_f_d   = 1'b0;
          match_f_d  = 1'b0;
          free_f_d   = 1'b0;
          best_len_d = '0;
          r_status_d = ST_OK;
          r_direct_d = 1'b0;
          r_ip_d     = '0;
          r_intf_d   = '0;
          r_metric_d = '0;
          r_len_d    = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt_q != (IdxW+1)'(ROUTE_ENTRIES)) begin
          pvld_d   = 1'b1;
          pidx_d   = rd_cnt_q[IdxW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1;
        end else if (!pvld_q) begin
          state_d = S_DECIDE;
        end
        if (pvld_q) begin
          if (!vld_q[pidx_q]) begin
            if (!free_f_q) begin
              free_f_d   = 1'b1;
              free_idx_d = pidx_q;
            end
          end else begin
            if (ent_rd.len == 6'd0 && ent_rd.prefix == 32'd0) begin
              dflt_f_d   = 1'b1;
              dflt_idx_d = pidx_q;
            end else if ((dest_q & len_mask(ent_rd.len)) == ent_rd.prefix &&
                         ent_rd.len > best_len_q) begin
              best_f_d   = 1'b1;
              best_idx_d = pidx_q;
              best_len_d = ent_rd.len;
            end
            if (!match_f_q && ent_rd.prefix == prefix_q && ent_rd.len == len_q) begin
              match_f_d   = 1'b1;
              match_idx_d = pidx_q;
            end
            if (kind_q == KIND_CLEAR && ent_rd.cnt != '0) begin
              vld_d[pidx_q] = 1'b0;
            end
          end
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        unique case (kind_q)
          KIND_LOOKUP: begin
            if (best_f_q || dflt_f_q) begin
              tgt_d   = best_f_q ? best_idx_q : dflt_idx_q;
              ent_ra  = tgt_d;
              state_d = S_RECV;
            end else begin
              r_status_d = ST_NOROUTE;
            end
          end
          KIND_ADD: begin
            if (has_q && 32'(intf_q) >= INTERFACES) begin
              r_status_d = ST_NOROUTE;
            end else if (match_f_q) begin
              if (has_q) begin
                tgt_d   = match_idx_q;
                ent_ra  = match_idx_q;
                state_d = S_RECV;
              end
            end else if (!free_f_q) begin
              r_status_d = ST_TABFULL;
            end else begin
              // new entry, with its first hop when one is carried
              vld_d[free_idx_q] = 1'b1;
              ent_we        = 1'b1;
              ent_wa        = free_idx_q;
              ent_wd.prefix = prefix_q;
              ent_wd.len    = len_q;
              ent_wd.metric = has_q ? metric_q : 32'd0;
              ent_wd.cnt    = has_q ? CntW'(1) : '0;
              ent_wd.rr     = '0;
              hop_we        = has_q;
              hop_wa        = hop_addr(free_idx_q, '0);
            end
          end
          KIND_DELETE: begin
            if (match_f_q) begin
              vld_d[match_idx_q] = 1'b0;
            end else begin
              r_status_d = ST_NOROUTE;
            end
          end
          default: begin
          end
        endcase
      end
      S_RECV: begin
        cur_d = ent_rd;
        k_d   = '0;
        if (kind_q == KIND_LOOKUP) begin
          r_metric_d = ent_rd.metric;
          r_len_d    = ent_rd.len;
          if (ent_rd.cnt == '0) begin
            r_direct_d = 1'b1;
            state_d    = S_DONE;
          end else begin
            k_d = (CntW'(ent_rd.rr) >= ent_rd.cnt || 32'(ent_rd.rr) >= NEXTHOPS)
                  ? '0 : ent_rd.rr;
            if (32'(k_d) + 1 >= NEXTHOPS || CntW'(32'(k_d) + 1) >= ent_rd.cnt) begin
              rr_nxt_d = '0;
            end else begin
              rr_nxt_d = HkW'(32'(k_d) + 1);
            end
            hop_ra  = hop_addr(tgt_q, k_d);
            state_d = S_LKHOP;
          end
        end else if (ent_rd.cnt == '0) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        hop_ra  = hop_addr(tgt_q, k_q);
        state_d = S_HCMP;
      end
      S_HCMP: begin
        if (hop_rd.gw == gw_q && hop_rd.intf == intf_q) begin
          r_status_d = ST_DUP;
          state_d    = S_DONE;
        end else if (32'(k_q) + 1 < 32'(cur_q.cnt) && 32'(k_q) + 1 < NEXTHOPS) begin
          k_d     = HkW'(32'(k_q) + 1);
          state_d = S_HRD;
        end else if (cur_q.cnt >= NhCnt) begin
          r_status_d = ST_HOPFULL;
          state_d    = S_DONE;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        hop_we        = 1'b1;
        hop_wa        = hop_addr(tgt_q, HkW'(cur_q.cnt));
        ent_we        = 1'b1;
        ent_wd.cnt    = cur_q.cnt + 1'b1;
        ent_wd.metric = metric_q;
        state_d       = S_DONE;
      end
      S_LKHOP: begin
        r_ip_d    = hop_rd.gw;
        r_intf_d  = hop_rd.intf;
        ent_we    = 1'b1;
        ent_wd.rr = rr_nxt_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      rd_cnt_q    <= '0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      rd_cnt_q    <= rd_cnt_d;
      pvld_q      <= pvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q   <= kind_i;
      dest_q   <= dest_ip_i;
      len_q    <= sat_len;
      prefix_q <= in_prefix;
      has_q    <= has_nexthop_i;
      gw_q     <= gateway_ip_i;
      intf_q   <= out_intf_i;
      metric_q <= metric_i;
    end
    pidx_q      <= pidx_d;
    best_f_q    <= best_f_d;
    dflt_f_q    <= dflt_f_d;
    match_f_q   <= match_f_d;
    free_f_q    <= free_f_d;
    best_idx_q  <= best_idx_d;
    dflt_idx_q  <= dflt_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    best_len_q  <= best_len_d;
    tgt_q       <= tgt_d;
    cur_q       <= cur_d;
    k_q         <= k_d;
    rr_nxt_q    <= rr_nxt_d;
    r_status_q  <= r_status_d;
    r_direct_q  <= r_direct_d;
    r_ip_q      <= r_ip_d;
    r_intf_q    <= r_intf_d;
    r_metric_q  <= r_metric_d;
    r_len_q     <= r_len_d;
    if (out_load) begin
      o_status_q <= r_status_q;
      o_direct_q <= r_direct_q;
      o_ip_q     <= r_ip_q;
      o_intf_q   <= r_intf_q;
      o_metric_q <= r_metric_q;
      o_len_q    <= r_len_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = o_status_q;
  assign route_direct_o       = o_direct_q;
  assign nexthop_ip_o         = o_ip_q;
  assign nexthop_intf_o       = o_intf_q;
  assign route_metric_o       = o_metric_q;
  assign matched_prefix_len_o = o_len_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lrt_checker.sv =====
`default_nettype none
module lrt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [2:0]  status_o,
  input wire        route_direct_o,
  input wire [31:0] nexthop_ip_o,
  input wire [3:0]  nexthop_intf_o,
  input wire [31:0] route_metric_o,
  input wire [5:0]  matched_prefix_len_o
);
  import lrt_pkg::*;

  // hold a pending result until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before accept");

  // a taken request keeps the engine busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      !route_direct_o && nexthop_ip_o == 32'd0 && nexthop_intf_o == 4'd0 &&
      route_metric_o == 32'd0 && matched_prefix_len_o == 6'd0)
    else $error("non-hit result carries route data");

  a_direct_nohop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && route_direct_o |-> nexthop_ip_o == 32'd0 && nexthop_intf_o == 4'd0)
    else $error("direct route carries a next hop");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> matched_prefix_len_o <= MAX_LEN && status_o <= ST_TABFULL)
    else $error("result field out of range");

endmodule

bind lpm_route_table_ecmp lrt_checker u_lrt_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .status_o             (status_o),
  .route_direct_o       (route_direct_o),
  .nexthop_ip_o         (nexthop_ip_o),
  .nexthop_intf_o       (nexthop_intf_o),
  .route_metric_o       (route_metric_o),
  .matched_prefix_len_o (matched_prefix_len_o)
);
`default_nettype wire

// ===== tb/sv/lpm_route_table_ecmp_tb.sv =====
`default_nettype none
module lpm_route_table_ecmp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrt_pkg::*;

  localparam int ENTRIES = 64;
  localparam int HOPS    = 4;
  localparam int INTFS   = 16;
  localparam int N_RAND  = 1600;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest;
    logic [5:0]  plen;
    logic        has_hop;
    logic [31:0] gw;
    logic [3:0]  intf;
    logic [31:0] metric;
  } route_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        direct;
    logic [31:0] hop_ip;
    logic [3:0]  hop_intf;
    logic [31:0] metric;
    logic [5:0]  mlen;
  } route_rsp_t;

  logic clk_i, rst_ni;
  logic in_valid_i, out_ready_i;
  logic in_ready_o, out_valid_o;
  logic [1:0]  kind_i;
  logic [31:0] dest_ip_i, gateway_ip_i, metric_i;
  logic [5:0]  prefix_len_i;
  logic        has_nexthop_i;
  logic [3:0]  out_intf_i;
  logic [2:0]  status_o;
  logic        route_direct_o;
  logic [31:0] nexthop_ip_o, route_metric_o;
  logic [3:0]  nexthop_intf_o;
  logic [5:0]  matched_prefix_len_o;

  lpm_route_table_ecmp uut (.*);

  // shadow route table
  logic        tv [ENTRIES];
  logic [31:0] tpfx [ENTRIES];
  logic [5:0]  tlen [ENTRIES];
  logic [31:0] tmet [ENTRIES];
  int          thops [ENTRIES];
  int          trr [ENTRIES];
  logic [31:0] tgw [ENTRIES][HOPS];
  logic [3:0]  tif [ENTRIES][HOPS];

  route_rsp_t pending_rsp[$];
  int errors = 0;
  bit stim_done = 0;
  bit quiet = 0;
  bit hold_off = 0;

  function automatic logic [31:0] net_mask(input logic [5:0] l);
    return (l == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - l));
  endfunction

  function automatic int exact_idx(input logic [31:0] p, input logic [5:0] l);
    for (int i = 0; i < ENTRIES; i++)
      if (tv[i] && tpfx[i] == p && tlen[i] == l) return i;
    return -1;
  endfunction

  function automatic route_rsp_t route_predict(input route_req_t r);
    route_rsp_t o;
    logic [5:0] l;
    logic [31:0] p;
    int e, best, dflt, rr;
    logic [5:0] longest;
    o = '0;
    l = (r.plen > MAX_LEN) ? MAX_LEN : r.plen;
    p = r.dest & net_mask(l);
    case (r.kind)
      KIND_LOOKUP: begin
        best = -1; dflt = -1; longest = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!tv[i]) continue;
          if (tlen[i] == 0 && tpfx[i] == 0) dflt = i;
          else if ((r.dest & net_mask(tlen[i])) == tpfx[i] && tlen[i] > longest) begin
            longest = tlen[i];
            best = i;
          end
        end
        if (best < 0) best = dflt;
        if (best < 0) begin
          o.status = ST_NOROUTE;
        end else begin
          o.status = ST_OK;
          o.metric = tmet[best];
          o.mlen = tlen[best];
          if (thops[best] == 0) begin
            o.direct = 1'b1;
          end else begin
            rr = trr[best];
            if (rr >= thops[best]) rr = 0;
            o.hop_ip = tgw[best][rr];
            o.hop_intf = tif[best][rr];
            rr++;
            if (rr >= thops[best]) rr = 0;
            trr[best] = rr;
          end
        end
      end
      KIND_ADD: begin
        e = exact_idx(p, l);
        o.status = ST_OK;
        if (r.has_hop && r.intf >= INTFS) return '{status: ST_NOROUTE, default: '0};
        if (e < 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (!tv[i]) begin e = i; break; end
          if (e < 0) return '{status: ST_TABFULL, default: '0};
          tv[e] = 1; tpfx[e] = p; tlen[e] = l; tmet[e] = 0; thops[e] = 0; trr[e] = 0;
        end else if (r.has_hop) begin
          for (int k = 0; k < thops[e]; k++)
            if (tgw[e][k] == r.gw && tif[e][k] == r.intf)
              return '{status: ST_DUP, default: '0};
          if (thops[e] >= HOPS) return '{status: ST_HOPFULL, default: '0};
        end
        if (r.has_hop) begin
          tgw[e][thops[e]] = r.gw;
          tif[e][thops[e]] = r.intf;
          thops[e]++;
          tmet[e] = r.metric;
        end
      end
      KIND_DELETE: begin
        e = exact_idx(p, l);
        if (e < 0) o.status = ST_NOROUTE;
        else tv[e] = 0;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (tv[i] && thops[i] != 0) tv[i] = 0;
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // pool of prefixes so adds, lookups and deletes collide often
  logic [31:0] pool_addr [8];
  logic [5:0]  pool_len [8];

  function automatic route_req_t rand_req();
    route_req_t r;
    int s;
    r.dest = $urandom;
    r.plen = $urandom_range(0, 63);
    r.gw = {30'd0, 2'($urandom_range(0, 3))} ^ ($urandom_range(0, 9) == 0 ? $urandom : 0);
    r.intf = $urandom_range(0, 15);
    r.metric = $urandom;
    r.has_hop = $urandom_range(0, 3) != 0;
    s = $urandom_range(0, 99);
    if (s < 45) r.kind = KIND_LOOKUP;
    else if (s < 80) r.kind = KIND_ADD;
    else if (s < 97) r.kind = KIND_DELETE;
    else r.kind = KIND_CLEAR;
    if ($urandom_range(0, 3) != 0) begin
      s = $urandom_range(0, 7);
      if (r.kind == KIND_LOOKUP)
        r.dest = pool_addr[s] | ($urandom & ~net_mask(pool_len[s]));
      else begin
        r.dest = pool_addr[s] | ($urandom_range(0, 1) ? ($urandom & ~net_mask(pool_len[s])) : 0);
        r.plen = pool_len[s];
      end
    end
    return r;
  endfunction

  // valid stays high from one request to the next unless an idle burst comes
  task automatic send_req(input route_req_t r, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= r.kind;
    dest_ip_i     <= r.dest;
    prefix_len_i  <= r.plen;
    has_nexthop_i <= r.has_hop;
    gateway_ip_i  <= r.gw;
    out_intf_i    <= r.intf;
    metric_i      <= r.metric;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rsp.push_back(route_predict(r));
  endtask

  // directed rows: request, whether the expectation is typed in, expectation
  typedef struct packed {
    route_req_t req;
    bit         fixed;
    route_rsp_t rsp;
  } dir_row_t;

  dir_row_t rows [$];

  initial begin
    route_req_t r;
    in_valid_i = 0; kind_i = 0; dest_ip_i = 0; prefix_len_i = 0;
    has_nexthop_i = 0; gateway_ip_i = 0; out_intf_i = 0; metric_i = 0;
    rst_ni = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tv[i] = 0; tpfx[i] = 0; tlen[i] = 0; tmet[i] = 0; thops[i] = 0; trr[i] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      pool_len[i] = (i == 0) ? 6'd0 : 6'($urandom_range(1, 32));
      pool_addr[i] = $urandom & net_mask(pool_len[i]);
    end
    rows = '{
      '{'{KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 1,
        '{ST_NOROUTE, 1'b0, 32'd0, 4'd0, 32'd0, 6'd0}},
      '{'{KIND_DELETE, 32'h0A00_0000, 6'd8, 1'b0, 32'd0, 4'd0, 32'd0}, 1,
        '{ST_NOROUTE, 1'b0, 32'd0, 4'd0, 32'd0, 6'd0}},
      '{'{KIND_ADD, 32'h0A01_0203, 6'd8, 1'b0, 32'd0, 4'd0, 32'hFFFF_FFFF}, 1,
        '{ST_OK, 1'b0, 32'd0, 4'd0, 32'd0, 6'd0}},
      '{'{KIND_LOOKUP, 32'h0AFF_FFFF, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 1,
        '{ST_OK, 1'b1, 32'd0, 4'd0, 32'd0, 6'd8}},
      '{'{KIND_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 4'd15, 32'hFFFF_FFFF}, 0, '0},
      '{'{KIND_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 4'd15, 32'd5}, 1,
        '{ST_DUP, 1'b0, 32'd0, 4'd0, 32'd0, 6'd0}},
      '{'{KIND_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'hFFFF_FFFF, 4'd0, 32'd7}, 0, '0},
      '{'{KIND_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'd0, 4'd3, 32'd8}, 0, '0},
      '{'{KIND_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'd1, 4'd3, 32'd9}, 0, '0},
      '{'{KIND_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'd2, 4'd3, 32'd9}, 1,
        '{ST_HOPFULL, 1'b0, 32'd0, 4'd0, 32'd0, 6'd0}},
      '{'{KIND_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_ADD, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'd9, 4'd9, 32'd1}, 0, '0},
      '{'{KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_ADD, 32'd0, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_LOOKUP, 32'h8000_0000, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 1,
        '{ST_OK, 1'b1, 32'd0, 4'd0, 32'd0, 6'd0}},
      '{'{KIND_CLEAR, 32'd0, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 1,
        '{ST_OK, 1'b0, 32'd0, 4'd0, 32'd0, 6'd0}},
      '{'{KIND_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_DELETE, 32'h0A00_0000, 6'd8, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_DELETE, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 0, '0},
      '{'{KIND_LOOKUP, 32'h1234_5678, 6'd0, 1'b0, 32'd0, 4'd0, 32'd0}, 1,
        '{ST_NOROUTE, 1'b0, 32'd0, 4'd0, 32'd0, 6'd0}}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_req(rows[i].req, 1);
      if (rows[i].fixed && pending_rsp[$] != rows[i].rsp)
        report_mismatch("directed row", i, 0);
    end
    // fill the table to hit table full, then flush it
    for (int i = 0; i < ENTRIES + 2; i++) begin
      r = '{KIND_ADD, 32'(i) << 8, 6'd24, 1'($urandom_range(0, 1)), $urandom, 4'd1, $urandom};
      send_req(r, 0);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      r = '{KIND_DELETE, 32'(i) << 8, 6'd24, 1'b0, 32'd0, 4'd0, 32'd0};
      send_req(r, 0);
    end
    // the receiver stalls long here while requests keep coming
    hold_off = 1;
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 20) hold_off = 0;
      if (i == N_RAND - 200) quiet = 1;
      send_req(rand_req(), !quiet);
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int stall;
    bit held;
    out_ready_i = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !held) begin
        held = 1;
        out_ready_i <= 1'b0;
        stall = 0;
        while (stall < 2000) begin
          @(posedge clk_i);
          stall++;
        end
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    route_rsp_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", {29'd0, status_o}, 0);
      end else begin
        w = pending_rsp.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (route_direct_o !== w.direct) report_mismatch("route_direct", route_direct_o, w.direct);
        if (nexthop_ip_o !== w.hop_ip) report_mismatch("nexthop_ip", nexthop_ip_o, w.hop_ip);
        if (nexthop_intf_o !== w.hop_intf)
          report_mismatch("nexthop_intf", nexthop_intf_o, w.hop_intf);
        if (route_metric_o !== w.metric) report_mismatch("route_metric", route_metric_o, w.metric);
        if (matched_prefix_len_o !== w.mlen)
          report_mismatch("matched_prefix_len", matched_prefix_len_o, w.mlen);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("lpm_route_table_ecmp_tb passed");
    end else begin
      $display("lpm_route_table_ecmp_tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("lpm_route_table_ecmp_tb failed");
    $finish;
  end

endmodule
`default_nettype wire
